// ===== hdl/tkmk_pkg.sv =====
package tkmk_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int PULSE_W     = 8;
    localparam int REL_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int TRACK_SH    = 6;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT_PULSE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 2'd2;

    localparam logic [PULSE_W-1:0] DOT_PULSE_RST  = 8'd24;
    localparam logic [PULSE_W-1:0] DASH_PULSE_RST = 8'd72;
    localparam logic [REL_W-1:0]   RELEASE_RST    = 4'd3;

    typedef enum logic [1:0] {
        MODE_CAL   = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_PULSE = 2'd2,
        MODE_WAIT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOT  = 2'd1,
        EV_DASH = 2'd2
    } t_event;

    // per-tick commands from the control stage to both lanes
    typedef struct packed {
        logic acc;
        logic fin;
        logic track;
    } t_lane_ctrl;

    // led_on sits in the lowest bit
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] dash_reference;
        logic [SAMPLE_BITS-1:0] dot_reference;
        t_mode                  phase;
        t_event                 key_event;
        logic                   led_on;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== hdl/tkmk_lane.sv =====
module tkmk_lane import tkmk_pkg::*; #(
    parameter int CAL_SAMPLES = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_lane_ctrl             i_ctrl,
    output logic                   o_touched,
    output logic [SAMPLE_BITS-1:0] o_next_base
);

    localparam int CNT_W     = $clog2(CAL_SAMPLES);
    localparam int SUM_W     = SAMPLE_BITS + CNT_W;
    localparam int DIV_SH    = SUM_W + CNT_W;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int TRK_W     = SAMPLE_BITS + TRACK_SH + 1;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << DIV_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

    logic [SAMPLE_BITS-1:0] r_base, n_base;
    logic [SUM_W-1:0]       r_sum, n_sum;

    logic [SUM_W-1:0]       w_sum_add;
    logic [PROD_W-1:0]      w_prod;
    logic [SAMPLE_BITS-1:0] w_avg;
    logic [TRK_W-1:0]       w_trk;
    logic [SAMPLE_BITS-1:0] w_thr;

    assign w_sum_add = r_sum + SUM_W'(i_sample);
    // floor(sum / CAL_SAMPLES) by reciprocal, exact over the whole sum range
    assign w_prod    = PROD_W'(w_sum_add) * PROD_W'(RECIP);
    assign w_avg     = w_prod[DIV_SH +: SAMPLE_BITS];

    // (63*base + sample) / 64
    assign w_trk = {1'b0, r_base, {TRACK_SH{1'b0}}} - TRK_W'(r_base) + TRK_W'(i_sample);

    assign w_thr     = r_base - (r_base >> 2);
    assign o_touched = (i_sample < w_thr);

    always_comb begin
        n_base = r_base;
        n_sum  = r_sum;
        if (i_ctrl.acc) begin
            n_sum = w_sum_add;
            if (i_ctrl.fin) begin
                n_base = w_avg;
                n_sum  = '0;
            end
        end else if (i_ctrl.track) begin
            n_base = w_trk[TRACK_SH +: SAMPLE_BITS];
        end
    end

    assign o_next_base = n_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_sum  <= '0;
        end else begin
            r_base <= n_base;
            r_sum  <= n_sum;
        end
    end

endmodule

// ===== hdl/tkmk_out_buf.sv =====
module tkmk_out_buf import tkmk_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;

    logic w_in_acc;
    logic w_take;

    assign o_ready  = !r_skid_vld;
    assign w_in_acc = i_valid && o_ready;
    assign w_take   = r_out_vld && i_ready;
    assign o_valid  = r_out_vld;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_in_acc) begin
            if (r_out_vld && !w_take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_in_acc) begin
            if (r_out_vld && !w_take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

// ===== hdl/touch_key_morse_keyer.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   dot_sample, dash_sample
// m_axis    out  m_axis_tvalid/m_axis_tready   led_on, key_event, phase, references
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// one item per cycle while s_axis_tready is high; each result is registered
// the mode and both baseline lanes update in the cycle the item is taken
// a two-entry output buffer keeps s_axis_tready high while one result waits
// synchronous active-low reset puts the block back into calibration
module touch_key_morse_keyer import tkmk_pkg::*; #(
    parameter int CAL_SAMPLES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [9:0] dot_sample, [19:10] dash_sample
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] led_on, [2:1] key_event, [4:3] phase, [14:5] dot_reference,
    // [24:15] dash_reference
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES - 1);

    logic [PULSE_W-1:0] r_dot_len, r_dash_len;
    logic [REL_W-1:0]   r_rel_ticks;

    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_cal_cnt, n_cal_cnt;
    logic [PULSE_W-1:0] r_tick, n_tick;
    logic [REL_W-1:0]   r_rel, n_rel;

    logic                   w_in_acc;
    logic                   w_buf_ready;
    logic [SAMPLE_BITS-1:0] w_dot_s, w_dash_s;
    logic                   w_dot_t, w_dash_t;
    logic [SAMPLE_BITS-1:0] w_dot_nb, w_dash_nb;
    t_lane_ctrl             w_ctrl;
    logic                   w_led;
    t_event                 w_event;
    logic [PULSE_W-1:0]     w_len;
    logic [PULSE_W-1:0]     w_tick_dec;
    logic [REL_W-1:0]       w_rel_inc;
    t_result                w_res;
    t_result                w_out;

    assign w_dot_s  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_dash_s = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    assign s_axis_tready = w_buf_ready;
    assign w_in_acc      = s_axis_tvalid && w_buf_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_len   <= DOT_PULSE_RST;
            r_dash_len  <= DASH_PULSE_RST;
            r_rel_ticks <= RELEASE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DOT_PULSE:  r_dot_len   <= i_cfg_data;
                CFG_DASH_PULSE: r_dash_len  <= i_cfg_data;
                CFG_RELEASE:    r_rel_ticks <= i_cfg_data[REL_W-1:0];
                default: ;
            endcase
        end
    end

    tkmk_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_dot_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_dot_s),
        .i_ctrl      (w_ctrl),
        .o_touched   (w_dot_t),
        .o_next_base (w_dot_nb)
    );

    tkmk_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_dash_lane (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (w_dash_s),
        .i_ctrl      (w_ctrl),
        .o_touched   (w_dash_t),
        .o_next_base (w_dash_nb)
    );

    // outputs of the control stage
    always_comb begin
        w_ctrl  = '0;
        w_led   = 1'b0;
        w_event = EV_NONE;
        w_len   = r_dot_len;
        if (w_in_acc) begin
            unique case (r_mode)
                MODE_CAL: begin
                    w_ctrl.acc = 1'b1;
                    w_ctrl.fin = (r_cal_cnt == CAL_LAST);
                end
                MODE_IDLE: begin
                    priority if (w_dot_t) begin
                        w_led   = 1'b1;
                        w_event = EV_DOT;
                        w_len   = r_dot_len;
                    end else if (w_dash_t) begin
                        w_led   = 1'b1;
                        w_event = EV_DASH;
                        w_len   = r_dash_len;
                    end else begin
                        w_ctrl.track = 1'b1;
                    end
                end
                MODE_PULSE: w_led = 1'b1;
                MODE_WAIT: ;
                default: ;
            endcase
        end
    end

    assign w_tick_dec = (r_tick != '0) ? r_tick - 1'b1 : r_tick;
    assign w_rel_inc  = r_rel + 1'b1;

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_cal_cnt = r_cal_cnt;
        n_tick    = r_tick;
        n_rel     = r_rel;
        if (w_in_acc) begin
            unique case (r_mode)
                MODE_CAL: begin
                    if (r_cal_cnt == CAL_LAST) begin
                        n_cal_cnt = '0;
                        n_mode    = MODE_IDLE;
                    end else begin
                        n_cal_cnt = r_cal_cnt + 1'b1;
                    end
                end
                MODE_IDLE: begin
                    if (w_dot_t || w_dash_t) begin
                        // a length of zero or one ends the pulse on the touch tick
                        if (w_len <= PULSE_W'(1)) begin
                            n_mode = MODE_WAIT;
                            n_rel  = '0;
                        end else begin
                            n_mode = MODE_PULSE;
                            n_tick = w_len - 1'b1;
                        end
                    end
                end
                MODE_PULSE: begin
                    n_tick = w_tick_dec;
                    if (w_tick_dec == '0) begin
                        n_mode = MODE_WAIT;
                        n_rel  = '0;
                    end
                end
                MODE_WAIT: begin
                    if (!w_dot_t && !w_dash_t) begin
                        if (w_rel_inc >= r_rel_ticks) begin
                            n_rel  = '0;
                            n_mode = MODE_IDLE;
                        end else begin
                            n_rel = w_rel_inc;
                        end
                    end else begin
                        n_rel = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CAL;
            r_cal_cnt <= '0;
            r_tick    <= '0;
            r_rel     <= '0;
        end else begin
            r_mode    <= n_mode;
            r_cal_cnt <= n_cal_cnt;
            r_tick    <= n_tick;
            r_rel     <= n_rel;
        end
    end

    always_comb begin
        w_res.led_on         = w_led;
        w_res.key_event      = w_event;
        w_res.phase          = n_mode;
        w_res.dot_reference  = w_dot_nb;
        w_res.dash_reference = w_dash_nb;
    end

    tkmk_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (w_buf_ready),
        .i_data  (w_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, w_out};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import tkmk_pkg::*;

    localparam int CAL_TICKS  = 32;
    localparam int IDLE_LIMIT = 1000;
    localparam int HOLD_TICKS = 80;
    localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [SAMPLE_BITS-1:0] dot;
        logic [SAMPLE_BITS-1:0] dash;
    } t_tick;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [9:0] dot_sample, [19:10] dash_sample
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] led_on, [2:1] key_event, [4:3] phase, [14:5] dot_reference,
    // [24:15] dash_reference
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // keyer state as the checker sees it
    t_mode                  kp_mode      = MODE_CAL;
    logic [SAMPLE_BITS-1:0] kp_dot_base  = '0;
    logic [SAMPLE_BITS-1:0] kp_dash_base = '0;
    logic [14:0]            kp_dot_sum   = '0;
    logic [14:0]            kp_dash_sum  = '0;
    logic [7:0]             kp_ticks     = '0;
    logic [REL_W-1:0]       kp_rel_cnt   = '0;
    logic [PULSE_W-1:0]     cfg_dot_len  = DOT_PULSE_RST;
    logic [PULSE_W-1:0]     cfg_dash_len = DASH_PULSE_RST;
    logic [REL_W-1:0]       cfg_rel_ticks = RELEASE_RST;

    t_tick       tick_q[$];
    t_result     key_reports_q[$];
    int          ticks_in_flight = 0;
    int          phase_items     = 0;
    int          mismatches      = 0;
    int          stall_cycles    = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int          hold_req        = 0;
    int          hold_seen       = 0;
    int          hold_left       = 0;
    bit          in_taken        = 1'b0;
    int          rest_dot        = 800;
    int          rest_dash       = 700;

    touch_key_morse_keyer #(
        .CAL_SAMPLES(CAL_TICKS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit under_thr(input logic [SAMPLE_BITS-1:0] s,
                                     input logic [SAMPLE_BITS-1:0] b);
        return s < b - (b >> 2);
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    task automatic start_pulse(input logic [PULSE_W-1:0] len);
        // zero length behaves like one
        if (len <= 1) begin
            kp_mode    = MODE_WAIT;
            kp_rel_cnt = '0;
        end else begin
            kp_mode  = MODE_PULSE;
            kp_ticks = len - 1'b1;
        end
    endtask

    task automatic keyer_tick(input t_tick tk, output t_result r);
        r.led_on    = 1'b0;
        r.key_event = EV_NONE;
        case (kp_mode)
            MODE_CAL: begin
                kp_dot_sum  += tk.dot;
                kp_dash_sum += tk.dash;
                if (int'(kp_ticks) + 1 >= CAL_TICKS) begin
                    kp_dot_base  = SAMPLE_BITS'(kp_dot_sum / CAL_TICKS);
                    kp_dash_base = SAMPLE_BITS'(kp_dash_sum / CAL_TICKS);
                    kp_dot_sum   = '0;
                    kp_dash_sum  = '0;
                    kp_ticks     = '0;
                    kp_mode      = MODE_IDLE;
                end else begin
                    kp_ticks++;
                end
            end
            MODE_IDLE: begin
                if (under_thr(tk.dot, kp_dot_base)) begin
                    r.led_on    = 1'b1;
                    r.key_event = EV_DOT;
                    start_pulse(cfg_dot_len);
                end else if (under_thr(tk.dash, kp_dash_base)) begin
                    r.led_on    = 1'b1;
                    r.key_event = EV_DASH;
                    start_pulse(cfg_dash_len);
                end else begin
                    kp_dot_base  = SAMPLE_BITS'((int'(kp_dot_base) * 63 + int'(tk.dot)) / 64);
                    kp_dash_base = SAMPLE_BITS'((int'(kp_dash_base) * 63 + int'(tk.dash)) / 64);
                end
            end
            MODE_PULSE: begin
                r.led_on = 1'b1;
                if (kp_ticks != 0) kp_ticks--;
                if (kp_ticks == 0) begin
                    kp_mode    = MODE_WAIT;
                    kp_rel_cnt = '0;
                end
            end
            default: begin
                if (!under_thr(tk.dot, kp_dot_base) && !under_thr(tk.dash, kp_dash_base)) begin
                    kp_rel_cnt++;
                    if (kp_rel_cnt >= cfg_rel_ticks) begin
                        kp_rel_cnt = '0;
                        kp_mode    = MODE_IDLE;
                    end
                end else begin
                    kp_rel_cnt = '0;
                end
            end
        endcase
        r.phase          = kp_mode;
        r.dot_reference  = kp_dot_base;
        r.dash_reference = kp_dash_base;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // sender: holds an offered item until it is taken
    always @(negedge i_clk) begin
        t_tick tk;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                tk = tick_q.pop_front();
                s_axis_tdata  <= {{(S_TDATA_W - 2 * SAMPLE_BITS){1'b0}}, tk.dash, tk.dot};
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_TICKS;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_tick   tk;
        bit      out_taken;
        in_taken  = s_axis_tvalid && s_axis_tready;
        out_taken = m_axis_tvalid && m_axis_tready;
        if (out_taken) begin
            got = m_axis_tdata[RESULT_W-1:0];
            ticks_in_flight--;
            if (key_reports_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = key_reports_q.pop_front();
                check_field("led_on", want.led_on, got.led_on);
                check_field("key_event", want.key_event, got.key_event);
                check_field("phase", want.phase, got.phase);
                check_field("dot_reference", want.dot_reference, got.dot_reference);
                check_field("dash_reference", want.dash_reference, got.dash_reference);
                check_field("padding", 0, m_axis_tdata[M_TDATA_W-1:RESULT_W]);
            end
        end
        if (in_taken) begin
            tk.dot  = s_axis_tdata[SAMPLE_BITS-1:0];
            tk.dash = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            keyer_tick(tk, want);
            key_reports_q.push_back(want);
        end
        if (!i_rst_n || in_taken || out_taken || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else if (++stall_cycles >= IDLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic push_tick(input int dot, input int dash);
        t_tick tk;
        tk.dot  = SAMPLE_BITS'(clip(dot, 0, FULL_SCALE));
        tk.dash = SAMPLE_BITS'(clip(dash, 0, FULL_SCALE));
        tick_q.push_back(tk);
        ticks_in_flight++;
        phase_items++;
    endtask

    // called at a falling edge; returns at a falling edge with nothing in flight
    task automatic drain();
        while (ticks_in_flight > 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DOT_PULSE:  cfg_dot_len   = data;
            CFG_DASH_PULSE: cfg_dash_len  = data;
            CFG_RELEASE:    cfg_rel_ticks = data[REL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_lengths(input int dot_len, input int dash_len, input int rel);
        cfg_write(CFG_DOT_PULSE, CFG_DATA_W'(dot_len));
        cfg_write(CFG_DASH_PULSE, CFG_DATA_W'(dash_len));
        // upper data bits must not reach the release count
        cfg_write(CFG_RELEASE, {4'($urandom_range(15)), 4'(rel)});
        cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom_range(255)));
    endtask

    function automatic int rest_sample(input int level);
        return level + int'($urandom_range(48)) - 24;
    endfunction

    function automatic int press_sample(input int level);
        return $urandom_range(level * 5 / 8);
    endfunction

    // one press, a drift of the resting level, or raw noise
    task automatic gen_sequence();
        int kind;
        int ch;
        int plen;
        kind = $urandom_range(19);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) push_tick($urandom_range(1023), $urandom_range(1023));
        end else if (kind == 1) begin
            rest_dot  = clip(rest_dot + int'($urandom_range(200)) - 100, 300, 1000);
            rest_dash = clip(rest_dash + int'($urandom_range(200)) - 100, 300, 1000);
            repeat ($urandom_range(4, 30)) push_tick(rest_sample(rest_dot), rest_sample(rest_dash));
        end else begin
            ch   = $urandom_range(2);
            plen = (ch == 1) ? int'(cfg_dash_len) : int'(cfg_dot_len);
            repeat ($urandom_range(1, 4))
                push_tick((ch != 1) ? press_sample(rest_dot) : rest_sample(rest_dot),
                          (ch != 0) ? press_sample(rest_dash) : rest_sample(rest_dash));
            repeat (plen + int'(cfg_rel_ticks) + int'($urandom_range(8))) begin
                // an occasional bounce while waiting for release
                if ($urandom_range(11) == 0)
                    push_tick(press_sample(rest_dot), rest_sample(rest_dash));
                else
                    push_tick(rest_sample(rest_dot), rest_sample(rest_dash));
            end
        end
    endtask

    task automatic run_phase(input int dot_len, input int dash_len, input int rel,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int n_items, input bit hold);
        set_lengths(dot_len, dash_len, rel);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        phase_items   = 0;
        while (phase_items < n_items) gen_sequence();
        // stall the output while the sender keeps offering
        if (hold) hold_req++;
        drain();
    endtask

    initial begin
        int thr_dot;
        int thr_dash;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // calibration with both extremes inside the average
        push_tick(1023, 0);
        push_tick(0, 1023);
        repeat (CAL_TICKS - 2) push_tick(800, 900);
        drain();

        // a sample right on the threshold is untouched and tracks
        push_tick(kp_dot_base - (kp_dot_base >> 2), kp_dash_base - (kp_dash_base >> 2));
        drain();

        // one below the dot threshold, pulse lengths still at reset values
        thr_dot = kp_dot_base - (kp_dot_base >> 2);
        push_tick(thr_dot - 1, 1023);
        repeat (cfg_dot_len) push_tick(1023, 1023);
        push_tick(0, 0);
        repeat (cfg_rel_ticks) push_tick(1023, 1023);
        drain();

        // zero lengths behave like one
        set_lengths(1, 0, 0);
        thr_dash = kp_dash_base - (kp_dash_base >> 2);
        push_tick(1023, thr_dash - 1);
        push_tick(1023, 1023);
        // both touched: dot wins
        push_tick(0, 0);
        push_tick(1023, 1023);
        push_tick(1023, 1023);
        push_tick(1023, 1023);
        drain();

        run_phase(3, 7, 2, 29, 54, 300, 1'b0);
        run_phase(255, 1, 15, 54, 29, 200, 1'b0);
        run_phase(2, 5, 1, 0, 0, 300, 1'b1);
        run_phase(9, 0, 0, 0, 0, 250, 1'b0);

        repeat (8) @(posedge i_clk);
        if (key_reports_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, key_reports_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tkmk_pkg.sv
hdl/tkmk_lane.sv
hdl/tkmk_out_buf.sv
hdl/touch_key_morse_keyer.sv
tb/tb_top.sv
